// File: rtl/rdc_pkg.sv
// Shared types and constants for the range distinct-count block.
// No dependencies; the top level and rdc_ctrl import this package.
package rdc_pkg;

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam int VALUE_W = 12;
   localparam int LEFT_W  = 10;
   localparam int TAG_W   = 16;
   localparam int COUNT_W = 11;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_P_LS,
      ST_P_PV,
      ST_P_CHK,
      ST_U_LEAF,
      ST_U_RD,
      ST_U_SUM,
      ST_Q_TEST,
      ST_Q_ADDL,
      ST_Q_RCHK,
      ST_Q_ADDR,
      ST_EMIT
   } state_type;

   typedef enum logic {
      PH_CLEAR,
      PH_SET
   } phase_type;

   typedef struct packed {
      logic ls;
      logic pv;
      logic tree;
   } mem_wr_type;

endpackage

// File: rtl/range_distinct_count_top.sv
// Range distinct-count engine. After reset the count tree is swept to zero with
// req_ready low. A push reads the last-seen and position tables, then walks the
// count tree from the leaf up to the root to set the new position, first walking
// it to clear the old position when the value recurs. A query makes one count-tree
// read per step through a single registered read port feeding one shared adder.
// Push to a full store and empty queries go straight to the emit state. The block
// takes one item at a time; a result may wait in the output register while the
// next item is already accepted.
module range_distinct_count_top #(
   parameter int POSITIONS  = 1024,
   parameter int VALUE_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic [rdc_pkg::VALUE_W-1:0] req_value,
   input  logic [rdc_pkg::LEFT_W-1:0]  req_left,
   input  logic [rdc_pkg::TAG_W-1:0]   req_tag,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rdc_pkg::COUNT_W-1:0] rsp_distinct_count,
   output logic [rdc_pkg::TAG_W-1:0]   rsp_tag_out,
   output logic                        rsp_overflow
);

   import rdc_pkg::*;

   localparam int PI = $clog2(POSITIONS);
   localparam int CW = $clog2(POSITIONS + 1);
   localparam int NW = $clog2(2 * POSITIONS);

   mem_wr_type            mem_wr;
   logic [VALUE_BITS-1:0] value_addr;
   logic [PI-1:0]         pos_addr;
   logic [PI-1:0]         ls_rdata;
   logic [VALUE_BITS-1:0] pv_rdata;
   logic [NW-1:0]         tree_waddr;
   logic [CW-1:0]         tree_wdata;
   logic [NW-1:0]         tree_raddr;
   logic [CW-1:0]         tree_rdata;

   rdc_ctrl #(
      .POSITIONS  (POSITIONS),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_value          (req_value),
      .req_left           (req_left),
      .req_tag            (req_tag),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_tag_out        (rsp_tag_out),
      .rsp_overflow       (rsp_overflow),
      .mem_wr             (mem_wr),
      .value_addr         (value_addr),
      .pos_addr           (pos_addr),
      .ls_rdata           (ls_rdata),
      .pv_rdata           (pv_rdata),
      .tree_waddr         (tree_waddr),
      .tree_wdata         (tree_wdata),
      .tree_raddr         (tree_raddr),
      .tree_rdata         (tree_rdata)
   );

   // last position of each value
   rdc_ram #(
      .DATA_W (PI),
      .ADDR_W (VALUE_BITS),
      .DEPTH  (1 << VALUE_BITS)
   ) u_last_seen (
      .clock   (clock),
      .wr_en   (mem_wr.ls),
      .wr_addr (value_addr),
      .wr_data (pos_addr),
      .rd_addr (value_addr),
      .rd_data (ls_rdata)
   );

   // value pushed at each position, validates last-seen entries
   rdc_ram #(
      .DATA_W (VALUE_BITS),
      .ADDR_W (PI),
      .DEPTH  (POSITIONS)
   ) u_pos_value (
      .clock   (clock),
      .wr_en   (mem_wr.pv),
      .wr_addr (pos_addr),
      .wr_data (value_addr),
      .rd_addr (ls_rdata),
      .rd_data (pv_rdata)
   );

   rdc_ram #(
      .DATA_W (CW),
      .ADDR_W (NW),
      .DEPTH  (2 * POSITIONS)
   ) u_count_tree (
      .clock   (clock),
      .wr_en   (mem_wr.tree),
      .wr_addr (tree_waddr),
      .wr_data (tree_wdata),
      .rd_addr (tree_raddr),
      .rd_data (tree_rdata)
   );

endmodule

// File: rtl/rdc_ram.sv
// Single-port-write, single-port-read memory with registered read data.
// Standalone; used for the last-seen table, the position table and the count tree.
module rdc_ram #(
   parameter int DATA_W = 1,
   parameter int ADDR_W = 1,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rdc_ctrl.sv
// Sequencer and shared adder for the range distinct-count block.
// Depends on rdc_pkg; drives the three rdc_ram instances in the top level.
module rdc_ctrl #(
   parameter int POSITIONS  = 1024,
   parameter int VALUE_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic [rdc_pkg::VALUE_W-1:0]           req_value,
   input  logic [rdc_pkg::LEFT_W-1:0]            req_left,
   input  logic [rdc_pkg::TAG_W-1:0]             req_tag,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rdc_pkg::COUNT_W-1:0]           rsp_distinct_count,
   output logic [rdc_pkg::TAG_W-1:0]             rsp_tag_out,
   output logic                                  rsp_overflow,
   output rdc_pkg::mem_wr_type                   mem_wr,
   output logic [VALUE_BITS-1:0]                 value_addr,
   output logic [$clog2(POSITIONS)-1:0]          pos_addr,
   input  logic [$clog2(POSITIONS)-1:0]          ls_rdata,
   input  logic [VALUE_BITS-1:0]                 pv_rdata,
   output logic [$clog2(2*POSITIONS)-1:0]        tree_waddr,
   output logic [$clog2(POSITIONS+1)-1:0]        tree_wdata,
   output logic [$clog2(2*POSITIONS)-1:0]        tree_raddr,
   input  logic [$clog2(POSITIONS+1)-1:0]        tree_rdata
);

   import rdc_pkg::*;

   localparam int PI   = $clog2(POSITIONS);
   localparam int PW   = $clog2(POSITIONS + 1);
   localparam int CW   = PW;
   localparam int NW   = $clog2(2 * POSITIONS);
   localparam int LW   = $clog2(2 * POSITIONS + 1);
   localparam int CMPW = (PW > LEFT_W) ? PW : LEFT_W;

   localparam logic [LW-1:0] NODE_BASE = LW'(POSITIONS);
   localparam logic [PW-1:0] FULL      = PW'(POSITIONS);
   localparam logic [NW-1:0] LAST_NODE = NW'(2 * POSITIONS - 1);
   localparam logic [NW-1:0] ROOT      = NW'(1);

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [PW-1:0]         np_ff, np_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [TAG_W-1:0]      tag_ff, tag_in;
   logic                  ovf_ff, ovf_in;
   logic [PI-1:0]         p_ff, p_in;
   logic [NW-1:0]         i_ff, i_in;
   logic [CW-1:0]         val_ff, val_in;
   logic [LW-1:0]         l_ff, l_in;
   logic [LW-1:0]         r_ff, r_in;
   logic [CW-1:0]         total_ff, total_in;
   logic [NW-1:0]         clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [TAG_W-1:0]      rsp_tag_ff, rsp_tag_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic          accept;
   logic          full;
   logic          left_lt;
   logic          seen;
   logic          out_free;
   logic          is_query;
   logic [LW-1:0] set_node;
   logic [LW-1:0] clr_node;
   logic [LW-1:0] r_dec;
   logic [CW-1:0] add_a;
   logic [CW-1:0] sum;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (np_ff == FULL);
   assign left_lt   = CMPW'(req_left) < CMPW'(np_ff);
   assign set_node  = NODE_BASE + LW'(np_ff);
   assign clr_node  = NODE_BASE + LW'(p_ff);
   assign r_dec     = r_ff - LW'(1);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // previous position is live only if it was filled and still holds this value
   assign seen      = (PW'(p_ff) < np_ff) && (pv_rdata == value_ff);

   // shared adder: walk partial sum or query total plus the tree read
   assign is_query  = (state_ff == ST_Q_ADDL) || (state_ff == ST_Q_ADDR);
   assign add_a     = is_query ? total_ff : val_ff;
   assign sum       = add_a + tree_rdata;

   assign value_addr = value_ff;
   assign pos_addr   = np_ff[PI-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_NODE) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_PUSH) begin
                  state_in = full ? ST_EMIT : ST_P_LS;
               end else begin
                  state_in = left_lt ? ST_Q_TEST : ST_EMIT;
               end
            end
         end
         ST_P_LS:   state_in = ST_P_PV;
         ST_P_PV:   state_in = ST_P_CHK;
         ST_P_CHK:  state_in = ST_U_LEAF;
         ST_U_LEAF: state_in = ST_U_RD;
         ST_U_RD: begin
            if (i_ff == ROOT) begin
               state_in = (phase_ff == PH_CLEAR) ? ST_U_LEAF : ST_IDLE;
            end else begin
               state_in = ST_U_SUM;
            end
         end
         ST_U_SUM:  state_in = ST_U_RD;
         ST_Q_TEST: begin
            if (l_ff >= r_ff)    state_in = ST_EMIT;
            else if (l_ff[0])    state_in = ST_Q_ADDL;
            else                 state_in = ST_Q_RCHK;
         end
         ST_Q_ADDL: state_in = ST_Q_RCHK;
         ST_Q_RCHK: state_in = r_ff[0] ? ST_Q_ADDR : ST_Q_TEST;
         ST_Q_ADDR: state_in = ST_Q_TEST;
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      np_in        = np_ff;
      value_in     = value_ff;
      tag_in       = tag_ff;
      ovf_in       = ovf_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      val_in       = val_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      total_in     = total_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mem_wr       = '0;
      tree_waddr   = i_ff;
      tree_wdata   = val_ff;
      tree_raddr   = i_ff ^ ROOT;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr.tree = 1'b1;
            tree_waddr  = clr_ff;
            tree_wdata  = '0;
            clr_in      = clr_ff + NW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               value_in = VALUE_BITS'(req_value);
               tag_in   = req_tag;
               ovf_in   = 1'b0;
               total_in = '0;
               l_in     = LW'(req_left) + NODE_BASE;
               r_in     = set_node;
               if ((req_op == OP_PUSH) && full) begin
                  ovf_in = 1'b1;
                  tag_in = '0;
               end
            end
         end
         ST_P_LS: begin
         end
         ST_P_PV: begin
            p_in = ls_rdata;
         end
         ST_P_CHK: begin
            mem_wr.ls = 1'b1;
            mem_wr.pv = 1'b1;
            if (seen) begin
               i_in     = clr_node[NW-1:0];
               val_in   = '0;
               phase_in = PH_CLEAR;
            end else begin
               i_in     = set_node[NW-1:0];
               val_in   = CW'(1);
               phase_in = PH_SET;
            end
         end
         ST_U_LEAF: begin
            mem_wr.tree = 1'b1;
         end
         ST_U_RD: begin
            if (i_ff == ROOT) begin
               if (phase_ff == PH_CLEAR) begin
                  i_in     = set_node[NW-1:0];
                  val_in   = CW'(1);
                  phase_in = PH_SET;
               end else begin
                  np_in = np_ff + PW'(1);
               end
            end
         end
         ST_U_SUM: begin
            mem_wr.tree = 1'b1;
            tree_waddr  = i_ff >> 1;
            tree_wdata  = sum;
            val_in      = sum;
            i_in        = i_ff >> 1;
         end
         ST_Q_TEST: begin
            tree_raddr = l_ff[NW-1:0];
         end
         ST_Q_ADDL: begin
            total_in = sum;
            l_in     = l_ff + LW'(1);
         end
         ST_Q_RCHK: begin
            tree_raddr = r_dec[NW-1:0];
            if (r_ff[0]) begin
               r_in = r_dec;
            end else begin
               l_in = l_ff >> 1;
               r_in = r_ff >> 1;
            end
         end
         ST_Q_ADDR: begin
            total_in = sum;
            l_in     = l_ff >> 1;
            r_in     = r_ff >> 1;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = COUNT_W'(total_ff);
               rsp_tag_in   = tag_ff;
               rsp_ovf_in   = ovf_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         np_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         np_ff        <= np_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff     <= phase_in;
      value_ff     <= value_in;
      tag_ff       <= tag_in;
      ovf_ff       <= ovf_in;
      p_ff         <= p_in;
      i_ff         <= i_in;
      val_ff       <= val_in;
      l_ff         <= l_in;
      r_ff         <= r_in;
      total_ff     <= total_in;
      rsp_count_ff <= rsp_count_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distinct_count = rsp_count_ff;
   assign rsp_tag_out        = rsp_tag_ff;
   assign rsp_overflow       = rsp_ovf_ff;

`ifndef SYNTH
   a_np_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (np_ff == $past(np_ff)) || (np_ff == $past(np_ff) + PW'(1)))
      else $error("fill count jumped");

   a_np_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ((total_ff <= np_ff) && (np_ff <= FULL)))
      else $error("answer exceeds filled positions");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit");

   a_walk_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_U_SUM) |-> (i_ff > ROOT))
      else $error("tree walk passed the root");
`endif

endmodule
